// File: sv/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
`timescale 1ns / 1ps
package sha1_pkg;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = H0;
      3'd1: init_h = H1;
      3'd2: init_h = H2;
      3'd3: init_h = H3;
      default: init_h = H4;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    if (t < 7'd20) round_k = K0;
    else if (t < 7'd40) round_k = K1;
    else if (t < 7'd60) round_k = K2;
    else round_k = K3;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    if (t < 7'd20) round_f = (b & c) ^ (~b & d);
    else if (t >= 7'd40 && t < 7'd60) round_f = (b & c) ^ (b & d) ^ (c & d);
    else round_f = b ^ c ^ d;
  endfunction
endpackage

// File: sv/sha1_stream_if.sv
// Valid/ready stream interface for the hash engine channels.
`timescale 1ns / 1ps
interface sha1_stream_if #(parameter int W = 10);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/sha1_sched_mem.sv
// Sixteen-word schedule memory with registered read port.
`timescale 1ns / 1ps
module sha1_sched_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);
  logic [31:0] mem [16];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/sha1_hash_engine.sv
// SHA-1 hash engine top level: byte gathering, padding and round sequencer.
//
// Usage: message bytes enter on channel in_ch, one beat per byte, payload
// {data_byte, has_byte, last}. A beat with last set closes the message; it
// may carry no byte. Digest words leave on out_ch as five beats, word 0
// first, payload {digest_word, word_index, last_word}.
// A byte that does not complete a block is stored and the engine stays
// ready for the next beat. A completed block is loaded into the schedule
// memory, four bytes gathered per word, then compressed in 80 rounds,
// rounds past 15 each making four schedule reads through the one
// registered port, and then folded into the chain value.
// A last beat sweeps the rest of the block with padding, compresses it,
// and adds a second padding block when the length does not fit; then the
// five words are offered, and a done state follows the fifth. Each word
// waits until taken, and a stalled receiver holds the engine, which
// accepts no beat meanwhile.
// Reset loads the initial chain value and clears the byte count and bit
// count; memory contents are undefined and always written before read.
`timescale 1ns / 1ps
module sha1_hash_engine import sha1_pkg::*; (
  input logic clk,
  input logic rst,
  sha1_stream_if.sink   in_ch,
  sha1_stream_if.source out_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_PAD = 7'b0000010, S_LOAD = 7'b0000100,
    S_RND = 7'b0001000, S_FOLD = 7'b0010000, S_OUT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t      state;
  in_item_t    item;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [5:0]  fill_count;
  logic [63:0] message_bits;
  logic        finishing, second_pad, padded;
  logic [7:0]  blk [64];
  logic [5:0]  pad_idx;
  logic [4:0]  ld_cnt;
  logic [7:0]  bread;
  logic [31:0] word_acc;
  logic [6:0]  rnd;
  logic [2:0]  phase;
  logic [31:0] xacc;
  logic [2:0]  oidx;
  logic        swe;
  logic [3:0]  swaddr, sraddr;
  logic [31:0] swdata, srdata;

  sha1_sched_mem u_sched (.clk, .we(swe), .waddr(swaddr), .wdata(swdata),
                          .raddr(sraddr), .rdata(srdata));

  assign item = in_ch.payload;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload = {h[oidx], oidx, oidx == 3'd4};

  // byte memory read port, registered
  logic [5:0] brd_addr;
  always_ff @(posedge clk) bread <= blk[brd_addr];

  logic [3:0] rt4;
  logic [31:0] tmp;
  assign rt4 = rnd[3:0];
  // rotate left by one applied to full xor
  logic [31:0] wx;
  assign wx = xacc ^ srdata;
  assign tmp = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e +
               ((rnd < 7'd16) ? srdata : {wx[30:0], wx[31]}) + round_k(rnd);

  always_comb begin
    swe = 1'b0; swaddr = rt4; swdata = {wx[30:0], wx[31]}; sraddr = rt4;
    brd_addr = {ld_cnt[3:0], phase[1:0]};
    if (state == S_LOAD) begin
      swaddr = ld_cnt[3:0];
      swdata = {word_acc[23:0], bread};
      swe = (phase == 3'd4);
    end else if (state == S_RND && rnd >= 7'd16) begin
      case (phase)
        3'd0: sraddr = rt4 - 4'd3;
        3'd1: sraddr = rt4 - 4'd8;
        3'd2: sraddr = rt4 - 4'd14;
        default: sraddr = rt4;
      endcase
      swe = (phase == 3'd4);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid && item.has_byte) blk[fill_count] <= item.data_byte;
    else if (state == S_PAD) begin
      if (pad_idx == fill_count && !second_pad) blk[pad_idx] <= PAD_BYTE;
      else if (pad_idx >= 6'd56 && !(fill_count > 6'd55 && !second_pad))
        blk[pad_idx] <= message_bits[8'd63 - {2'b0, pad_idx[2:0], 3'b0} -: 8];
      else blk[pad_idx] <= 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill_count <= '0; message_bits <= '0; finishing <= 1'b0;
      second_pad <= 1'b0; padded <= 1'b0; oidx <= '0; ld_cnt <= '0; phase <= '0;
      rnd <= '0; pad_idx <= '0;
      for (int i = 0; i < 5; i++) h[i] <= init_h(3'(i));
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          finishing <= item.last;
          second_pad <= 1'b0;
          if (item.has_byte) begin
            message_bits <= message_bits + 64'd8;
            fill_count <= fill_count + 6'd1;
          end
          if (item.has_byte && fill_count == 6'd63) begin
            state <= S_LOAD; ld_cnt <= '0; phase <= '0; padded <= 1'b0;
          end else if (item.last) begin
            state <= S_PAD; padded <= 1'b1;
            pad_idx <= item.has_byte ? fill_count + 6'd1 : fill_count;
          end
        end
        S_PAD: begin
          // sweep from pad byte (or block start) to end of block
          pad_idx <= pad_idx + 6'd1;
          if (pad_idx == 6'd63) begin
            state <= S_LOAD; ld_cnt <= '0; phase <= '0;
          end
        end
        S_LOAD: begin
          // gather 4 bytes then write word
          if (phase != 3'd0) word_acc <= {word_acc[23:0], bread};
          if (phase == 3'd4) begin
            phase <= '0;
            if (ld_cnt == 5'd15) begin
              state <= S_RND; rnd <= '0;
              a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            end
            ld_cnt <= ld_cnt + 5'd1;
          end else phase <= phase + 3'd1;
        end
        S_RND: begin
          if (phase == 3'd4) begin
            e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
            phase <= '0;
            rnd <= rnd + 7'd1;
            if (rnd == 7'd79) state <= S_FOLD;
          end else if (rnd < 7'd16) begin
            phase <= 3'd4;
          end else begin
            phase <= phase + 3'd1;
            xacc <= (phase == 3'd1) ? srdata : xacc ^ srdata;
          end
        end
        S_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (!finishing) state <= S_IDLE;
          else if (!padded) begin
            // last byte filled the block; padding starts a fresh one
            padded <= 1'b1; state <= S_PAD; pad_idx <= fill_count;
          end else if (fill_count > 6'd55 && !second_pad) begin
            // length did not fit; second block carries zeros and count
            second_pad <= 1'b1; state <= S_PAD; pad_idx <= '0;
          end else begin
            state <= S_OUT; oidx <= '0;
          end
        end
        S_OUT: if (out_ch.ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd4) state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE; fill_count <= '0; message_bits <= '0; finishing <= 1'b0;
          for (int i = 0; i < 5; i++) h[i] <= init_h(3'(i));
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/sha1_hash_checker.sv
// Port-level checker for the hash engine, bound to the top level.
`timescale 1ns / 1ps
module sha1_hash_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [35:0] out_payload
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while digest pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("digest beat changed under stall");
  a_lastw: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_payload[0] == (out_payload[3:1] == 3'd4)))
    else $error("last_word mismatch");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_payload[0] |=> out_valid)
    else $error("digest words not contiguous");
endmodule

bind sha1_hash_engine sha1_hash_checker u_chk (.clk(clk), .rst(rst),
  .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_payload(out_ch.payload));
